>>> rtl/core/i2cbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_pkg
// shared types and constants for the tick-driven i2c master
// ----------------------------------------------------------------------------
package i2cbb_pkg;

    localparam int unsigned HALF_PERIOD_TICKS = 1;
    localparam int unsigned DELAY_W           = 10;

    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_CMD_WRITE  = 2'd1;
    localparam logic [1:0] ACT_WORD_WRITE = 2'd2;
    localparam logic [1:0] ACT_PORT_READ  = 2'd3;

    localparam logic [1:0] REG_ADDRESS_BITS = 2'd0;
    localparam logic [1:0] REG_COMMAND_MASK = 2'd1;
    localparam logic [1:0] REG_READ_COMMAND = 2'd2;

    localparam logic [7:0] ADDRESS_BITS_RST = 8'd64;
    localparam logic [7:0] COMMAND_MASK_RST = 8'd62;
    localparam logic [7:0] READ_COMMAND_RST = 8'd77;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] command_word;
        logic        sda_level_in;
    } i2cbb_cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_is_input;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } i2cbb_res_t;

endpackage

>>> rtl/core/i2c_bitbang_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bitbang_master_top
// tick-driven i2c master: start, two bytes with ack clocks, stop
//
//   port    | dir | handshake          | word
//   --------+-----+--------------------+-----------------------------
//   cmd     | in  | cmd_valid/ready    | i2cbb_cmd_t, one bus tick
//   res     | out | res_valid/ready    | i2cbb_res_t, line levels
//   cfg     | in  | cfg_wr_en only     | cfg_index, cfg_data
//
// one word a cycle while res is not stalled; the result is registered and appears in the cycle after acceptance
// the sequencer state and the result register update at the same edge
// cmd_ready stays high while the result register is empty or being taken
// a stall on res holds the result and stops intake, state is kept
// reset puts the bus sequencer idle and loads the register defaults
// ----------------------------------------------------------------------------
module i2c_bitbang_master_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  i2cbb_pkg::i2cbb_cmd_t cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output i2cbb_pkg::i2cbb_res_t res,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data
);
    import i2cbb_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START_HI = 4'd1;
    localparam logic [3:0] PH_START_LO = 4'd2;
    localparam logic [3:0] PH_BIT_LO   = 4'd3;
    localparam logic [3:0] PH_BIT_HI   = 4'd4;
    localparam logic [3:0] PH_ACK_LO   = 4'd5;
    localparam logic [3:0] PH_ACK_HI   = 4'd6;
    localparam logic [3:0] PH_STOP_A   = 4'd7;
    localparam logic [3:0] PH_STOP_B   = 4'd8;
    localparam logic [3:0] PH_STOP_C   = 4'd9;

    localparam logic [DELAY_W:0] HALF_END = (DELAY_W + 1)'(HALF_PERIOD_TICKS);

    logic [7:0]         address_bits_reg;
    logic [7:0]         command_mask_reg;
    logic [7:0]         read_command_reg;

    logic [3:0]         phase_reg,    phase_next;
    logic [3:0]         bit_idx_reg,  bit_idx_next;
    logic               byte_idx_reg, byte_idx_next;
    logic [7:0]         tx_shift_reg, tx_shift_next;
    logic [7:0]         rx_shift_reg, rx_shift_next;
    logic [7:0]         second_reg,   second_next;
    logic [1:0]         kind_reg,     kind_next;
    logic [DELAY_W-1:0] delay_reg,    delay_next;

    logic               res_valid_reg;
    i2cbb_res_t         res_reg, res_next;

    logic               accept;
    logic               reading;
    logic [DELAY_W:0]   delay_sum;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_bits_reg <= ADDRESS_BITS_RST;
            command_mask_reg <= COMMAND_MASK_RST;
            read_command_reg <= READ_COMMAND_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ADDRESS_BITS: address_bits_reg <= cfg_data;
                REG_COMMAND_MASK: command_mask_reg <= cfg_data;
                REG_READ_COMMAND: read_command_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // one bus tick
    always_comb
    begin
        phase_next    = phase_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        second_next   = second_reg;
        kind_next     = kind_reg;
        delay_next    = delay_reg;
        reading       = 1'b0;
        delay_sum     = '0;

        res_next.scl_level    = 1'b1;
        res_next.sda_level    = 1'b1;
        res_next.sda_is_input = 1'b0;
        res_next.busy_res     = 1'b0;
        res_next.done_res     = 1'b0;

        // start on an idle tick
        if (phase_reg == PH_IDLE && cmd.action != ACT_TICK)
        begin
            kind_next = cmd.action;
            case (cmd.action)
                ACT_CMD_WRITE:
                begin
                    tx_shift_next = (cmd.command_word[14:7] & command_mask_reg)
                                    | address_bits_reg;
                    second_next   = cmd.command_word[7:0];
                end
                ACT_WORD_WRITE:
                begin
                    tx_shift_next = cmd.command_word[15:8];
                    second_next   = cmd.command_word[7:0];
                end
                default:
                begin
                    tx_shift_next = read_command_reg;
                    second_next   = '0;
                    rx_shift_next = '0;
                end
            endcase
            byte_idx_next = 1'b0;
            bit_idx_next  = '0;
            delay_next    = '0;
            phase_next    = PH_START_HI;
        end

        if (phase_next != PH_IDLE)
        begin
            reading           = (kind_next == ACT_PORT_READ) && byte_idx_next;
            res_next.busy_res = 1'b1;
            unique case (phase_next)
                PH_START_HI: begin res_next.scl_level = 1'b1; res_next.sda_level = 1'b1; end
                PH_START_LO: begin res_next.scl_level = 1'b1; res_next.sda_level = 1'b0; end
                PH_BIT_LO, PH_BIT_HI:
                begin
                    res_next.scl_level = (phase_next == PH_BIT_HI);
                    if (reading)
                    begin
                        res_next.sda_level    = 1'b1;
                        res_next.sda_is_input = 1'b1;
                    end
                    else
                    begin
                        res_next.sda_level = tx_shift_next[7];
                    end
                end
                PH_ACK_LO:   begin res_next.scl_level = 1'b0; res_next.sda_level = 1'b1; end
                PH_ACK_HI:   begin res_next.scl_level = 1'b1; res_next.sda_level = 1'b1; end
                PH_STOP_A:   begin res_next.scl_level = 1'b0; res_next.sda_level = 1'b0; end
                PH_STOP_B:   begin res_next.scl_level = 1'b1; res_next.sda_level = 1'b0; end
                default:     begin res_next.scl_level = 1'b1; res_next.sda_level = 1'b1; end
            endcase

            delay_sum = {1'b0, delay_next} + 1'b1;
            if (delay_sum >= HALF_END)
            begin
                delay_next = '0;
                unique case (phase_next)
                    PH_START_HI: phase_next = PH_START_LO;
                    PH_START_LO:
                    begin
                        phase_next   = PH_BIT_LO;
                        bit_idx_next = '0;
                    end
                    PH_BIT_LO:   phase_next = PH_BIT_HI;
                    PH_BIT_HI:
                    begin
                        if (reading)
                        begin
                            rx_shift_next = {rx_shift_next[6:0], cmd.sda_level_in};
                        end
                        else
                        begin
                            tx_shift_next = {tx_shift_next[6:0], 1'b0};
                        end
                        bit_idx_next = bit_idx_next + 4'd1;
                        phase_next   = (bit_idx_next >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
                    end
                    PH_ACK_LO:   phase_next = PH_ACK_HI;
                    PH_ACK_HI:
                    begin
                        if (!byte_idx_next)
                        begin
                            byte_idx_next = 1'b1;
                            tx_shift_next = second_next;
                            bit_idx_next  = '0;
                            phase_next    = PH_BIT_LO;
                        end
                        else
                        begin
                            phase_next = PH_STOP_A;
                        end
                    end
                    PH_STOP_A:   phase_next = PH_STOP_B;
                    PH_STOP_B:   phase_next = PH_STOP_C;
                    default:
                    begin
                        phase_next        = PH_IDLE;
                        byte_idx_next     = 1'b0;
                        bit_idx_next      = '0;
                        res_next.busy_res = 1'b0;
                        res_next.done_res = 1'b1;
                    end
                endcase
            end
            else
            begin
                delay_next = delay_sum[DELAY_W-1:0];
            end
        end

        res_next.read_data = rx_shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_idx_reg   <= '0;
            byte_idx_reg  <= 1'b0;
            tx_shift_reg  <= '0;
            rx_shift_reg  <= '0;
            second_reg    <= '0;
            kind_reg      <= ACT_TICK;
            delay_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                bit_idx_reg  <= bit_idx_next;
                byte_idx_reg <= byte_idx_next;
                tx_shift_reg <= tx_shift_next;
                rx_shift_reg <= rx_shift_next;
                second_reg   <= second_next;
                kind_reg     <= kind_next;
                delay_reg    <= delay_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // checks
    a_result_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("result register not loaded after accepted word");

    a_idle_counters_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bit_idx_reg == '0 && !byte_idx_reg))
        else $error("bit or byte index left set while idle");

    a_done_ends_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done reported while still busy");

    a_input_only_reading: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.sda_is_input)
            |-> (res_reg.busy_res && kind_reg == ACT_PORT_READ))
        else $error("sda released outside a port read");

    a_bit_index_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        bit_idx_reg <= 4'd8)
        else $error("bit index beyond one byte");

endmodule

>>> dv/tb_i2c_bitbang_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_bitbang_master_top
// self-checking bench for the tick-driven i2c master
//
// each accepted tick word goes through a bus-level model of the sequencer
// returned words checked field by field, in order, against the model
// tests: field extremes and every transaction kind, actions while busy
// or on the done tick, a register sweep, randomised rounds
// registers written only with the bus idle and nothing outstanding
// both handshakes idle at random, except in one long stretch
// ----------------------------------------------------------------------------
module tb_i2c_bitbang_master_top;

    import i2cbb_pkg::*;

    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_START_HI,
        BUS_START_LO,
        BUS_BIT_LO,
        BUS_BIT_HI,
        BUS_ACK_LO,
        BUS_ACK_HI,
        BUS_STOP_A,
        BUS_STOP_B,
        BUS_STOP_C
    } bus_phase_e;

    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    i2cbb_cmd_t cmd;
    logic       res_valid;
    logic       res_ready = 1'b0;
    i2cbb_res_t res;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // bus model state and register copies
    bus_phase_e  bus_ph;
    logic [3:0]  bit_cnt;
    logic [1:0]  byte_sel;
    logic [7:0]  tx_shift;
    logic [7:0]  rx_shift;
    logic [7:0]  next_byte;
    logic [1:0]  xfer_kind;
    int unsigned half_cnt;
    logic [7:0]  addr_bits;
    logic [7:0]  cmd_mask;
    logic [7:0]  rd_cmd;

    i2cbb_res_t levels_due[$];
    int         mismatch_count = 0;
    bit         calm = 1'b0;

    i2c_bitbang_master_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic i2cbb_res_t bus_tick(input i2cbb_cmd_t w);
        i2cbb_res_t r;
        logic       rd;
        r = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        if (bus_ph == BUS_IDLE && w.action != ACT_TICK)
        begin
            xfer_kind = w.action;
            case (w.action)
                ACT_CMD_WRITE:
                begin
                    tx_shift  = (w.command_word[14:7] & cmd_mask) | addr_bits;
                    next_byte = w.command_word[7:0];
                end
                ACT_WORD_WRITE:
                begin
                    tx_shift  = w.command_word[15:8];
                    next_byte = w.command_word[7:0];
                end
                default:
                begin
                    tx_shift  = rd_cmd;
                    next_byte = 8'd0;
                    rx_shift  = 8'd0;
                end
            endcase
            byte_sel = 2'd0;
            bit_cnt  = 4'd0;
            half_cnt = 0;
            bus_ph   = BUS_START_HI;
        end
        if (bus_ph != BUS_IDLE)
        begin
            rd = (xfer_kind == ACT_PORT_READ) && (byte_sel == 2'd1);
            r.busy_res = 1'b1;
            case (bus_ph)
                BUS_START_HI: begin r.scl_level = 1'b1; r.sda_level = 1'b1; end
                BUS_START_LO: begin r.scl_level = 1'b1; r.sda_level = 1'b0; end
                BUS_BIT_LO, BUS_BIT_HI:
                begin
                    r.scl_level = (bus_ph == BUS_BIT_HI);
                    if (rd)
                    begin
                        r.sda_level    = 1'b1;
                        r.sda_is_input = 1'b1;
                    end
                    else
                    begin
                        r.sda_level = tx_shift[7];
                    end
                end
                BUS_ACK_LO:   begin r.scl_level = 1'b0; r.sda_level = 1'b1; end
                BUS_ACK_HI:   begin r.scl_level = 1'b1; r.sda_level = 1'b1; end
                BUS_STOP_A:   begin r.scl_level = 1'b0; r.sda_level = 1'b0; end
                BUS_STOP_B:   begin r.scl_level = 1'b1; r.sda_level = 1'b0; end
                default:      begin r.scl_level = 1'b1; r.sda_level = 1'b1; end
            endcase
            half_cnt = half_cnt + 1;
            if (half_cnt >= HALF_PERIOD_TICKS)
            begin
                half_cnt = 0;
                case (bus_ph)
                    BUS_START_HI: bus_ph = BUS_START_LO;
                    BUS_START_LO:
                    begin
                        bus_ph  = BUS_BIT_LO;
                        bit_cnt = 4'd0;
                    end
                    BUS_BIT_LO:   bus_ph = BUS_BIT_HI;
                    BUS_BIT_HI:
                    begin
                        if (rd)
                            rx_shift = {rx_shift[6:0], w.sda_level_in};
                        else
                            tx_shift = {tx_shift[6:0], 1'b0};
                        bit_cnt = bit_cnt + 4'd1;
                        bus_ph  = (bit_cnt >= 4'd8) ? BUS_ACK_LO : BUS_BIT_LO;
                    end
                    BUS_ACK_LO:   bus_ph = BUS_ACK_HI;
                    BUS_ACK_HI:
                    begin
                        if (byte_sel == 2'd0)
                        begin
                            byte_sel = 2'd1;
                            tx_shift = next_byte;
                            bit_cnt  = 4'd0;
                            bus_ph   = BUS_BIT_LO;
                        end
                        else
                        begin
                            bus_ph = BUS_STOP_A;
                        end
                    end
                    BUS_STOP_A:   bus_ph = BUS_STOP_B;
                    BUS_STOP_B:   bus_ph = BUS_STOP_C;
                    default:
                    begin
                        bus_ph     = BUS_IDLE;
                        byte_sel   = 2'd0;
                        bit_cnt    = 4'd0;
                        r.busy_res = 1'b0;
                        r.done_res = 1'b1;
                    end
                endcase
            end
        end
        r.read_data = rx_shift;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        i2cbb_res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (levels_due.size() == 0)
            begin
                report_mismatch("result word with nothing outstanding");
            end
            else
            begin
                want = levels_due.pop_front();
                check_field("scl_level", res.scl_level, want.scl_level);
                check_field("sda_level", res.sda_level, want.sda_level);
                check_field("sda_is_input", res.sda_is_input, want.sda_is_input);
                check_field("busy_res", res.busy_res, want.busy_res);
                check_field("done_res", res.done_res, want.done_res);
                check_field("read_data", res.read_data, want.read_data);
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
        res_ready <= calm || ($urandom_range(0, 99) >= 18);

    task automatic send_word(input i2cbb_cmd_t w);
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (!cmd_ready);
        levels_due.push_back(bus_tick(w));
        if (!calm && $urandom_range(0, 99) < 18)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 30);
        end
    endtask

    task automatic send_tick(input logic [1:0] act, input logic [15:0] word,
                             input logic sda);
        i2cbb_cmd_t w;
        w.action       = act;
        w.command_word = word;
        w.sda_level_in = sda;
        send_word(w);
    endtask

    // one transaction from an idle bus, ticked until the bus is idle again
    task automatic run_xfer(input logic [1:0] act, input logic [15:0] word,
                            input int sda_mode, input bit noisy);
        logic sda;
        sda = (sda_mode == SDA_RANDOM) ? 1'($urandom) : (sda_mode == SDA_HIGH);
        send_tick(act, word, sda);
        while (bus_ph != BUS_IDLE)
        begin
            sda = (sda_mode == SDA_RANDOM) ? 1'($urandom) : (sda_mode == SDA_HIGH);
            send_tick(noisy ? 2'($urandom_range(1, 3)) : ACT_TICK, 16'($urandom), sda);
        end
    endtask

    task automatic settle;
        while (bus_ph != BUS_IDLE)
            send_tick(ACT_TICK, 16'($urandom), 1'($urandom));
        cmd_valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [7:0] val);
        case (idx)
            REG_ADDRESS_BITS: addr_bits = val;
            REG_COMMAND_MASK: cmd_mask  = val;
            REG_READ_COMMAND: rd_cmd    = val;
            default: ;
        endcase
    endtask

    // writes all three registers and the unused index
    task automatic set_regs(input logic [7:0] addr, input logic [7:0] mask,
                            input logic [7:0] rdc);
        logic [7:0] vals[4];
        vals = '{addr, mask, rdc, 8'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            apply_reg(2'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed;
        send_tick(ACT_TICK, 16'h0000, 1'b0);
        send_tick(ACT_TICK, 16'hffff, 1'b1);
        run_xfer(ACT_CMD_WRITE, 16'h0000, SDA_RANDOM, 1'b0);
        run_xfer(ACT_CMD_WRITE, 16'hffff, SDA_RANDOM, 1'b0);
        run_xfer(ACT_WORD_WRITE, 16'h0000, SDA_RANDOM, 1'b0);
        run_xfer(ACT_WORD_WRITE, 16'hffff, SDA_RANDOM, 1'b0);
        run_xfer(ACT_WORD_WRITE, 16'ha55a, SDA_RANDOM, 1'b0);
        run_xfer(ACT_PORT_READ, 16'hffff, SDA_HIGH, 1'b0);
        run_xfer(ACT_PORT_READ, 16'h0000, SDA_LOW, 1'b0);
        settle();
    endtask

    // actions while busy and on the done tick are ignored
    task automatic test_busy_actions;
        run_xfer(ACT_PORT_READ, 16'($urandom), SDA_RANDOM, 1'b1);
        run_xfer(ACT_CMD_WRITE, 16'($urandom), SDA_RANDOM, 1'b1);
        run_xfer(ACT_WORD_WRITE, 16'($urandom), SDA_RANDOM, 1'b1);
        settle();
    endtask

    task automatic test_reg_sweep;
        logic [7:0] sweep[5][3];
        sweep = '{'{8'h00, 8'h00, 8'h00}, '{8'hff, 8'hff, 8'hff},
                  '{8'h00, 8'hff, 8'ha5}, '{8'hff, 8'h00, 8'h5a},
                  '{ADDRESS_BITS_RST, COMMAND_MASK_RST, READ_COMMAND_RST}};
        foreach (sweep[k])
        begin
            set_regs(sweep[k][0], sweep[k][1], sweep[k][2]);
            run_xfer(ACT_CMD_WRITE, 16'($urandom), SDA_RANDOM, 1'b0);
            run_xfer(ACT_WORD_WRITE, 16'($urandom), SDA_RANDOM, 1'b0);
            run_xfer(ACT_PORT_READ, 16'($urandom), SDA_RANDOM, 1'b0);
            settle();
        end
    endtask

    task automatic test_random_traffic;
        i2cbb_cmd_t w;
        for (int round = 0; round < 3; round++)
        begin
            set_regs(8'($urandom), 8'($urandom), 8'($urandom));
            calm = (round == 1);
            for (int n = 0; n < 300; n++)
            begin
                w.command_word = 16'($urandom);
                w.sda_level_in = 1'($urandom);
                if (bus_ph == BUS_IDLE)
                    w.action = ($urandom_range(0, 99) < 85) ?
                               2'($urandom_range(1, 3)) : ACT_TICK;
                else
                    w.action = ($urandom_range(0, 99) < 75) ? ACT_TICK : 2'($urandom);
                send_word(w);
            end
            settle();
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_ADDRESS_BITS;
        cfg_data  <= 8'd0;
        bus_ph    = BUS_IDLE;
        bit_cnt   = 4'd0;
        byte_sel  = 2'd0;
        tx_shift  = 8'd0;
        rx_shift  = 8'd0;
        next_byte = 8'd0;
        xfer_kind = ACT_TICK;
        half_cnt  = 0;
        addr_bits = ADDRESS_BITS_RST;
        cmd_mask  = COMMAND_MASK_RST;
        rd_cmd    = READ_COMMAND_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_busy_actions();
        test_reg_sweep();
        test_random_traffic();

        settle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && levels_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
